// File: rtl/core/fsp_pkg.sv
// ----------------------------------------------------------------------------
// fsp_pkg
// Shared types and constants for the first-free slot pool.
// ----------------------------------------------------------------------------
package fsp_pkg;

    // Field widths
    localparam int VALUE_W     = 24;
    localparam int STATUS_W    = 2;
    localparam int SLOT_IDX_W  = 4;
    localparam int OCC_W       = 5;
    localparam int SLOTS_CFG_W = 5;
    localparam int LIMIT_W     = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    // Request opcodes
    localparam logic OP_PRODUCE = 1'b0;
    localparam logic OP_CONSUME = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LIMIT = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ITEM_LIMIT   = 1'b1;

    // Configuration reset values
    localparam logic [SLOTS_CFG_W-1:0] SLOTS_IN_USE_RST = 5'd16;
    localparam logic [LIMIT_W-1:0]     ITEM_LIMIT_RST   = 16'd10000;

    typedef struct packed {
        logic               op;
        logic [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [VALUE_W-1:0]    item_value;
        logic [OCC_W-1:0]      occupied;
    } out_item_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;    // capture request, restart scan
        logic step;    // examine one slot
        logic commit;  // update slot state, issue RAM access
        logic emit;    // move result into the output register
    } fsp_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic scan_done;  // all active slots examined
        logic out_free;   // output register can take a beat
    } fsp_stat_t;

endpackage

// File: rtl/core/first_free_slot_pool.sv
// ----------------------------------------------------------------------------
// first_free_slot_pool
// Bounded slot pool: produce fills the lowest empty slot, consume drains the
// lowest occupied one, with full/empty/limit rejection.
// ----------------------------------------------------------------------------
// One request at a time. After a beat is taken on the input, the sequencer
// walks the valid bits of the active slots one per cycle (this single scan
// finds the target slot and counts occupancy), then commits, then loads the
// output register once that register is free; the scan over the valid bits
// of min(slots_in_use, SLOTS) slots makes a request take longer as the
// active slot count grows. A finished result waits in the output register,
// and the next input beat is taken while it waits; only a second result that
// finds the output register still full stalls. Slot values live in a RAM
// with registered read; slot valid bits, produce and consume totals live in
// flops cleared by reset, so the pool is usable right after reset.
// slots_in_use above SLOTS saturates to SLOTS; slots above the active count
// keep their contents but are neither searched nor counted. The item limit
// is checked before capacity. Config writes are taken at any time but must
// only happen with no request in flight.
// ----------------------------------------------------------------------------
module first_free_slot_pool
    import fsp_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,

    // config write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // request channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,

    // result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data
);

    fsp_cmd_t  cmd;
    fsp_stat_t stat;

    // sequencer: idle -> scan -> output
    fsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // slot state, scan datapath and output register
    fsp_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // rejected requests report no slot and no value
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != ST_DONE) |->
            (out_data.slot_index == '0) && (out_data.item_value == '0))
        else $error("rejected beat carries slot or value");

    // only one request in flight: an input beat drops ready next cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while busy");

    // a produce rejected as full returns no value
    a_produce_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ST_FULL) |-> (out_data.item_value == '0))
        else $error("full status with nonzero value");

endmodule

// File: rtl/core/fsp_ram.sv
// ----------------------------------------------------------------------------
// fsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fsp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/fsp_ctrl.sv
// ----------------------------------------------------------------------------
// fsp_ctrl
// Sequencer: accept a request, scan the slots, commit, hand off the result.
// ----------------------------------------------------------------------------
module fsp_ctrl
    import fsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  fsp_stat_t stat,
    output fsp_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // commit is a single-cycle pulse per request
    a_commit_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> !cmd.commit)
        else $error("commit held for more than one cycle");

    // load only ever follows from idle, and leads into the scan
    a_load_to_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_SCAN))
        else $error("load did not start a scan");

    // a result is emitted only after a commit has happened
    a_emit_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (state_reg == S_OUT) && !cmd.load && !cmd.step)
        else $error("emit outside the output phase");

endmodule

// File: rtl/core/fsp_dpath.sv
// ----------------------------------------------------------------------------
// fsp_dpath
// Slot state, config registers, scan counter, slot RAM and output register.
// ----------------------------------------------------------------------------
module fsp_dpath
    import fsp_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  in_item_t               in_data,
    input  fsp_cmd_t               cmd,
    output fsp_stat_t              stat,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_data
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    // control state
    logic [SLOTS_CFG_W-1:0] cfg_slots_reg;
    logic [LIMIT_W-1:0]     cfg_limit_reg;
    logic [SLOTS-1:0]       valid_reg;
    logic [LIMIT_W-1:0]     produced_reg;
    logic [LIMIT_W-1:0]     consumed_reg;
    logic                   out_valid_reg;

    // per-request working registers
    in_item_t               req_reg;
    logic                   limit_hit_reg;
    logic [CNT_W-1:0]       idx_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   found_reg;
    logic [IDX_W-1:0]       pos_reg;
    logic [STATUS_W-1:0]    res_status_reg;
    logic [IDX_W-1:0]       res_pos_reg;
    logic [CNT_W-1:0]       res_occ_reg;
    logic                   res_take_reg;
    out_item_t              out_reg;

    logic [CNT_W-1:0]       lim;
    logic                   want;
    logic                   cur_valid;
    logic                   success;
    logic                   is_produce;
    logic [VALUE_W-1:0]     ram_rdata;

    // active slot count, saturated at SLOTS
    always_comb
    begin
        if (int'(cfg_slots_reg) > SLOTS)
        begin
            lim = CNT_W'(SLOTS);
        end
        else
        begin
            lim = CNT_W'(cfg_slots_reg);
        end
    end

    assign is_produce = (req_reg.op == OP_PRODUCE);
    assign want       = (req_reg.op == OP_CONSUME);
    assign cur_valid  = valid_reg[idx_reg[IDX_W-1:0]];
    assign success    = !limit_hit_reg && found_reg;

    assign stat.scan_done = (idx_reg >= lim);
    assign stat.out_free  = !out_valid_reg || out_ready;

    // config, slot valid bits, totals, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_slots_reg <= SLOTS_IN_USE_RST;
            cfg_limit_reg <= ITEM_LIMIT_RST;
            valid_reg     <= '0;
            produced_reg  <= '0;
            consumed_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SLOTS_IN_USE: cfg_slots_reg <= cfg_data[SLOTS_CFG_W-1:0];
                    CFG_ITEM_LIMIT:   cfg_limit_reg <= cfg_data[LIMIT_W-1:0];
                    default:          ;
                endcase
            end
            if (cmd.commit && success)
            begin
                if (is_produce)
                begin
                    valid_reg[pos_reg] <= 1'b1;
                    produced_reg       <= produced_reg + LIMIT_W'(1);
                end
                else
                begin
                    valid_reg[pos_reg] <= 1'b0;
                    consumed_reg       <= consumed_reg + LIMIT_W'(1);
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request capture, slot scan, result staging
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= in_data;
            limit_hit_reg <= (in_data.op == OP_PRODUCE) ? (produced_reg >= cfg_limit_reg)
                                                        : (consumed_reg >= cfg_limit_reg);
            idx_reg   <= '0;
            count_reg <= '0;
            found_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else if (cmd.step)
        begin
            if (cur_valid)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (!found_reg && (cur_valid == want))
            begin
                found_reg <= 1'b1;
                pos_reg   <= idx_reg[IDX_W-1:0];
            end
            idx_reg <= idx_reg + CNT_W'(1);
        end

        if (cmd.commit)
        begin
            res_take_reg <= success && !is_produce;
            res_pos_reg  <= success ? pos_reg : '0;
            if (limit_hit_reg)
            begin
                res_status_reg <= ST_LIMIT;
                res_occ_reg    <= count_reg;
            end
            else if (!found_reg)
            begin
                res_status_reg <= is_produce ? ST_FULL : ST_EMPTY;
                res_occ_reg    <= count_reg;
            end
            else
            begin
                res_status_reg <= ST_DONE;
                res_occ_reg    <= is_produce ? count_reg + CNT_W'(1)
                                             : count_reg - CNT_W'(1);
            end
        end

        if (cmd.emit)
        begin
            out_reg.status     <= res_status_reg;
            out_reg.slot_index <= SLOT_IDX_W'(res_pos_reg);
            out_reg.item_value <= res_take_reg ? ram_rdata : '0;
            out_reg.occupied   <= OCC_W'(res_occ_reg);
        end
    end

    fsp_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (cmd.commit && success && is_produce),
        .waddr (pos_reg),
        .wdata (req_reg.value),
        .re    (cmd.commit && success && !is_produce),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // a successful produce marks its slot occupied
    a_produce_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && success && is_produce |=> valid_reg[$past(pos_reg)])
        else $error("produced slot not marked valid");

    // a successful consume frees its slot
    a_consume_clears_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && success && !is_produce |=> !valid_reg[$past(pos_reg)])
        else $error("consumed slot still marked valid");

    // the occupancy seen at commit never exceeds the active slot count
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (count_reg <= lim))
        else $error("occupancy count above active slots");

endmodule
